// ----- src/asmlex_pkg.sv -----
// ----------------------------------------------------------------------------
// Assembly lexer package
// Widths, character codes, token kinds and the result record of the
// byte-serial assembler tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package asmlex_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int COLUMN_BITS = 16;
	localparam int LINE_BITS   = 16;
	localparam int LENGTH_BITS = 16;
	localparam int CHAR_W      = 8;
	localparam int KIND_W      = 4;
	localparam int NUMBER_W    = 32;
	localparam int COLUMN_W    = 16;
	localparam int LINE_W      = 16;
	localparam int MAX_RESULTS = 3;
	localparam int COUNT_W     = 2;

	localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2c;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5b;
	localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5d;
	localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5f;
	localparam logic [CHAR_W-1:0] CH_A_LOW  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_F_LOW  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_X_LOW  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_Z_LOW  = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7b;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7d;
	localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;
	localparam logic [CHAR_W-1:0] HEX_TEN   = 8'h0a;

	typedef enum logic [KIND_W-1:0] {
		KIND_IDENT   = 4'd0,
		KIND_NUMBER  = 4'd1,
		KIND_COMMA   = 4'd2,
		KIND_LBRACK  = 4'd3,
		KIND_RBRACK  = 4'd4,
		KIND_LBRACE  = 4'd5,
		KIND_RBRACE  = 4'd6,
		KIND_PLUS    = 4'd7,
		KIND_MINUS   = 4'd8,
		KIND_UNKNOWN = 4'd9,
		KIND_EOF     = 4'd10
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [NUMBER_W-1:0]  value;
		logic                 ovf;
		logic [LENGTH_BITS-1:0] length;
		logic [COLUMN_W-1:0]  column;
		logic [LINE_W-1:0]    line;
		logic [CHAR_W-1:0]    uchar;
	} result_t;

endpackage

`default_nettype wire

// ----- src/asmlex_if.sv -----
// ----------------------------------------------------------------------------
// Assembly lexer channels
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
`default_nettype none

interface asmlex_in_if;
	logic                           valid;
	logic                           ready;
	logic [asmlex_pkg::CHAR_W-1:0]  char_code;
	logic                           final_byte;

	modport source (output valid, output char_code, output final_byte, input ready);
	modport sink   (input valid, input char_code, input final_byte, output ready);
endinterface

interface asmlex_out_if;
	logic                                valid;
	logic                                ready;
	logic [asmlex_pkg::KIND_W-1:0]       token_kind;
	logic [asmlex_pkg::NUMBER_W-1:0]     number_value;
	logic                                value_overflow;
	logic [asmlex_pkg::LENGTH_BITS-1:0]  token_length;
	logic [asmlex_pkg::COLUMN_W-1:0]     start_column;
	logic [asmlex_pkg::LINE_W-1:0]       line_number;
	logic [asmlex_pkg::CHAR_W-1:0]       unknown_char;
	logic                                last_result;

	modport source (output valid, output token_kind, output number_value,
		output value_overflow, output token_length, output start_column,
		output line_number, output unknown_char, output last_result, input ready);
	modport sink   (input valid, input token_kind, input number_value,
		input value_overflow, input token_length, input start_column,
		input line_number, input unknown_char, input last_result, output ready);
endinterface

`default_nettype wire

// ----- src/assembly_lexer_top.sv -----
// ----------------------------------------------------------------------------
// Assembly lexer
// A byte passes the input register, then the token buffer, to the output.
// Throughput: one byte per cycle while tokens.ready is high and a byte gives
// at most one token; a byte with k tokens (k <= 3) holds the next byte that
// gives tokens until the token buffer drains all k, one per ready cycle.
// Reset: arst_n clears all lexer state, line and column to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module assembly_lexer_top (
	input  wire logic      clk,
	input  wire logic      arst_n,
	asmlex_in_if.sink      bytes,
	asmlex_out_if.source   tokens
);

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_IDENT   = 2'd1,
		MODE_NUMBER  = 2'd2,
		MODE_COMMENT = 2'd3
	} mode_t;

	typedef struct packed {
		logic                                hex_seen;
		logic                                hex_stopped;
		logic [asmlex_pkg::VALUE_BITS-1:0]   hex_acc;
		logic [asmlex_pkg::VALUE_BITS-1:0]   dec_acc;
		logic                                hex_ovf;
		logic                                dec_ovf;
		logic [asmlex_pkg::LENGTH_BITS-1:0]  chars;
	} num_t;

	localparam int VW = asmlex_pkg::VALUE_BITS;

	function automatic logic is_digit(logic [asmlex_pkg::CHAR_W-1:0] c);
		return c >= asmlex_pkg::CH_ZERO && c <= asmlex_pkg::CH_NINE;
	endfunction

	function automatic logic is_letter(logic [asmlex_pkg::CHAR_W-1:0] c);
		logic [asmlex_pkg::CHAR_W-1:0] l;
		l = c | asmlex_pkg::CASE_BIT;
		return !c[asmlex_pkg::CHAR_W-1] && l >= asmlex_pkg::CH_A_LOW
			&& l <= asmlex_pkg::CH_Z_LOW;
	endfunction

	function automatic logic [asmlex_pkg::LENGTH_BITS-1:0] sat_inc(
		logic [asmlex_pkg::LENGTH_BITS-1:0] n);
		return (n == asmlex_pkg::LENGTH_MAX) ? n : n + 1'b1;
	endfunction

	function automatic num_t number_byte(num_t s, logic [asmlex_pkg::CHAR_W-1:0] c);
		num_t                          r;
		logic [asmlex_pkg::CHAR_W-1:0] l;
		logic [3:0]                    nib;
		logic [VW+3:0]                 hsum;
		logic [VW+3:0]                 dsum;
		r    = s;
		l    = c | asmlex_pkg::CASE_BIT;
		nib  = is_digit(c) ? c[3:0] : 4'(l - asmlex_pkg::CH_A_LOW + asmlex_pkg::HEX_TEN);
		hsum = {s.hex_acc, 4'b0000} + (VW+4)'(nib);
		dsum = (VW+4)'({s.dec_acc, 3'b000}) + (VW+4)'({s.dec_acc, 1'b0}) + (VW+4)'(nib);
		if (c == asmlex_pkg::CH_X_LOW) begin
			if (!(s.chars == asmlex_pkg::LENGTH_BITS'(1) && !s.hex_seen && s.hex_acc == '0))
				r.hex_stopped = 1'b1;
			r.hex_seen = 1'b1;
		end else if (is_digit(c) || (l >= asmlex_pkg::CH_A_LOW && l <= asmlex_pkg::CH_F_LOW)) begin
			if (!s.hex_stopped) begin
				if (|hsum[VW+3:VW]) begin
					r.hex_acc = '1;
					r.hex_ovf = 1'b1;
				end else begin
					r.hex_acc = hsum[VW-1:0];
				end
			end
			if (is_digit(c) && !s.hex_seen) begin
				if (|dsum[VW+3:VW]) begin
					r.dec_acc = '1;
					r.dec_ovf = 1'b1;
				end else begin
					r.dec_acc = dsum[VW-1:0];
				end
			end
		end else begin
			r.hex_stopped = 1'b1;
		end
		r.chars = sat_inc(s.chars);
		return r;
	endfunction

	function automatic asmlex_pkg::result_t flush_res(mode_t m, num_t s,
		logic [asmlex_pkg::COLUMN_BITS-1:0] start, logic [asmlex_pkg::LINE_BITS-1:0] line);
		asmlex_pkg::result_t r;
		r        = '0;
		r.kind   = (m == MODE_NUMBER) ? asmlex_pkg::KIND_NUMBER : asmlex_pkg::KIND_IDENT;
		r.length = s.chars;
		r.column = asmlex_pkg::COLUMN_W'(start);
		r.line   = asmlex_pkg::LINE_W'(line);
		if (m == MODE_NUMBER) begin
			r.value = asmlex_pkg::NUMBER_W'(s.hex_seen ? s.hex_acc : s.dec_acc);
			r.ovf   = s.hex_seen ? s.hex_ovf : s.dec_ovf;
		end
		return r;
	endfunction

	function automatic asmlex_pkg::kind_t punct_kind(logic [asmlex_pkg::CHAR_W-1:0] c);
		asmlex_pkg::kind_t k;
		case (c)
			asmlex_pkg::CH_COMMA:  k = asmlex_pkg::KIND_COMMA;
			asmlex_pkg::CH_LBRACK: k = asmlex_pkg::KIND_LBRACK;
			asmlex_pkg::CH_RBRACK: k = asmlex_pkg::KIND_RBRACK;
			asmlex_pkg::CH_LBRACE: k = asmlex_pkg::KIND_LBRACE;
			asmlex_pkg::CH_RBRACE: k = asmlex_pkg::KIND_RBRACE;
			asmlex_pkg::CH_PLUS:   k = asmlex_pkg::KIND_PLUS;
			asmlex_pkg::CH_MINUS:  k = asmlex_pkg::KIND_MINUS;
			default:               k = asmlex_pkg::KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	// input register
	logic                               valid_s1;
	logic [asmlex_pkg::CHAR_W-1:0]      char_s1;
	logic                               final_s1;

	// lexer state
	mode_t                              mode_q, mode_d;
	num_t                               num_q, num_d;
	logic [asmlex_pkg::COLUMN_BITS-1:0] start_q, start_d;
	logic [asmlex_pkg::COLUMN_BITS-1:0] col_q, col_d;
	logic [asmlex_pkg::LINE_BITS-1:0]   line_q, line_d;

	// token buffer
	asmlex_pkg::result_t                slot_q [asmlex_pkg::MAX_RESULTS];
	logic [asmlex_pkg::COUNT_W-1:0]     cnt_q;
	logic [asmlex_pkg::COUNT_W-1:0]     rd_q;

	asmlex_pkg::result_t                res [asmlex_pkg::MAX_RESULTS];
	logic [asmlex_pkg::COUNT_W-1:0]     nres;
	logic                               ends;
	asmlex_pkg::result_t                cur;
	logic                               take;
	logic                               drain;
	logic                               go;

	always_comb begin
		mode_d  = mode_q;
		num_d   = num_q;
		start_d = start_q;
		line_d  = line_q;
		col_d   = col_q + 1'b1;
		nres    = '0;
		ends    = 1'b0;
		for (int i = 0; i < asmlex_pkg::MAX_RESULTS; i++)
			res[i] = '0;

		case (mode_q)
			MODE_COMMENT: begin
				if (char_s1 == asmlex_pkg::CH_LF) begin
					mode_d = MODE_IDLE;
					line_d = line_q + 1'b1;
					col_d  = '0;
				end
			end
			MODE_IDENT: begin
				if (is_letter(char_s1) || is_digit(char_s1) || char_s1 == asmlex_pkg::CH_UNDER)
					num_d.chars = sat_inc(num_q.chars);
				else
					ends = 1'b1;
			end
			MODE_NUMBER: begin
				if (is_digit(char_s1) || char_s1 == asmlex_pkg::CH_X_LOW
					|| (num_q.hex_seen && is_letter(char_s1)))
					num_d = number_byte(num_q, char_s1);
				else
					ends = 1'b1;
			end
			default: ends = 1'b1;
		endcase

		if (ends) begin
			if (mode_q == MODE_IDENT || mode_q == MODE_NUMBER) begin
				res[nres] = flush_res(mode_q, num_q, start_q, line_q);
				nres      = nres + 1'b1;
			end
			mode_d = MODE_IDLE;
			if (char_s1 == asmlex_pkg::CH_SPACE || char_s1 == asmlex_pkg::CH_TAB) begin
				mode_d = MODE_IDLE;
			end else if (char_s1 == asmlex_pkg::CH_CR || char_s1 == asmlex_pkg::CH_LF) begin
				line_d = line_q + 1'b1;
				col_d  = '0;
			end else if (char_s1 == asmlex_pkg::CH_HASH) begin
				mode_d = MODE_COMMENT;
			end else if (is_letter(char_s1)) begin
				mode_d      = MODE_IDENT;
				start_d     = col_q;
				num_d.chars = asmlex_pkg::LENGTH_BITS'(1);
			end else if (is_digit(char_s1)) begin
				mode_d  = MODE_NUMBER;
				start_d = col_q;
				num_d   = number_byte('0, char_s1);
			end else begin
				res[nres].kind   = punct_kind(char_s1);
				res[nres].length = asmlex_pkg::LENGTH_BITS'(1);
				res[nres].column = asmlex_pkg::COLUMN_W'(col_q);
				res[nres].line   = asmlex_pkg::LINE_W'(line_q);
				res[nres].uchar  = (punct_kind(char_s1) == asmlex_pkg::KIND_UNKNOWN)
					? char_s1 : '0;
				nres = nres + 1'b1;
			end
		end

		if (final_s1) begin
			if (mode_d == MODE_IDENT || mode_d == MODE_NUMBER) begin
				res[nres] = flush_res(mode_d, num_d, start_d, line_d);
				nres      = nres + 1'b1;
			end
			res[nres].kind   = asmlex_pkg::KIND_EOF;
			res[nres].column = asmlex_pkg::COLUMN_W'(col_d);
			res[nres].line   = asmlex_pkg::LINE_W'(line_d);
			nres    = nres + 1'b1;
			mode_d  = MODE_IDLE;
			num_d   = '0;
			start_d = '0;
			col_d   = '0;
			line_d  = '0;
		end
	end

	assign take  = tokens.valid && tokens.ready;
	assign drain = take && (rd_q == cnt_q - 1'b1);
	assign go    = valid_s1 && (cnt_q == '0 || drain || nres == '0);

	assign bytes.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			char_s1  <= bytes.char_code;
			final_s1 <= bytes.final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			num_q   <= '0;
			start_q <= '0;
			col_q   <= '0;
			line_q  <= '0;
		end else if (go) begin
			mode_q  <= mode_d;
			num_q   <= num_d;
			start_q <= start_d;
			col_q   <= col_d;
			line_q  <= line_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (go && nres != '0) begin
			cnt_q <= nres;
			rd_q  <= '0;
		end else if (drain) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (take) begin
			rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go && nres != '0) begin
			for (int i = 0; i < asmlex_pkg::MAX_RESULTS; i++)
				slot_q[i] <= res[i];
		end
	end

	assign cur = slot_q[rd_q];

	assign tokens.valid          = cnt_q != '0;
	assign tokens.token_kind     = cur.kind;
	assign tokens.number_value   = cur.value;
	assign tokens.value_overflow = cur.ovf;
	assign tokens.token_length   = cur.length;
	assign tokens.start_column   = cur.column;
	assign tokens.line_number    = cur.line;
	assign tokens.unknown_char   = cur.uchar;
	assign tokens.last_result    = rd_q == cnt_q - 1'b1;

endmodule

`default_nettype wire

// ----- src/asmlex_checker.sv -----
// ----------------------------------------------------------------------------
// Assembly lexer checker
// Port-level checks on the token channel of the lexer top level.
// ----------------------------------------------------------------------------
`default_nettype none

module asmlex_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [asmlex_pkg::KIND_W-1:0]       token_kind,
	input wire logic [asmlex_pkg::NUMBER_W-1:0]     number_value,
	input wire logic                                value_overflow,
	input wire logic [asmlex_pkg::LENGTH_BITS-1:0]  token_length,
	input wire logic [asmlex_pkg::CHAR_W-1:0]       unknown_char,
	input wire logic                                last_result
);

	// valid stays high while a token is stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("token dropped while stalled");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == asmlex_pkg::KIND_EOF
		|-> last_result && token_length == '0 && number_value == '0)
		else $error("eof token malformed");

	a_value_number_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != asmlex_pkg::KIND_NUMBER
		|-> number_value == '0 && !value_overflow)
		else $error("value on a non-number token");

	a_uchar_unknown_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != asmlex_pkg::KIND_UNKNOWN |-> unknown_char == '0)
		else $error("byte on a known token");

endmodule

bind assembly_lexer_top asmlex_checker u_asmlex_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (tokens.valid),
	.out_ready      (tokens.ready),
	.token_kind     (tokens.token_kind),
	.number_value   (tokens.number_value),
	.value_overflow (tokens.value_overflow),
	.token_length   (tokens.token_length),
	.unknown_char   (tokens.unknown_char),
	.last_result    (tokens.last_result)
);

`default_nettype wire
